/* rtl/skc_pkg.sv */
// ----------------------------------------------------------------------------
// SKIP32 cipher package
// Shared constants, the F table and the pipeline stage type.
// ----------------------------------------------------------------------------
`default_nettype none

package skc_pkg;

  localparam int unsigned ROUNDS   = 24;
  localparam int unsigned NumStage = 2 * ROUNDS;
  localparam int unsigned RoundW   = (ROUNDS > 2) ? $clog2(ROUNDS) : 1;
  localparam int unsigned KeyBytes = 10;
  localparam int unsigned KeyW     = 8 * KeyBytes;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CfgKeyZeroToSeven = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyEightNine   = 2'd1;

  localparam logic CmdEncrypt = 1'b1;

  localparam logic [7:0] FBOX [256] = '{
    8'ha3, 8'hd7, 8'h09, 8'h83, 8'hf8, 8'h48, 8'hf6, 8'hf4,
    8'hb3, 8'h21, 8'h15, 8'h78, 8'h99, 8'hb1, 8'haf, 8'hf9,
    8'he7, 8'h2d, 8'h4d, 8'h8a, 8'hce, 8'h4c, 8'hca, 8'h2e,
    8'h52, 8'h95, 8'hd9, 8'h1e, 8'h4e, 8'h38, 8'h44, 8'h28,
    8'h0a, 8'hdf, 8'h02, 8'ha0, 8'h17, 8'hf1, 8'h60, 8'h68,
    8'h12, 8'hb7, 8'h7a, 8'hc3, 8'he9, 8'hfa, 8'h3d, 8'h53,
    8'h96, 8'h84, 8'h6b, 8'hba, 8'hf2, 8'h63, 8'h9a, 8'h19,
    8'h7c, 8'hae, 8'he5, 8'hf5, 8'hf7, 8'h16, 8'h6a, 8'ha2,
    8'h39, 8'hb6, 8'h7b, 8'h0f, 8'hc1, 8'h93, 8'h81, 8'h1b,
    8'hee, 8'hb4, 8'h1a, 8'hea, 8'hd0, 8'h91, 8'h2f, 8'hb8,
    8'h55, 8'hb9, 8'hda, 8'h85, 8'h3f, 8'h41, 8'hbf, 8'he0,
    8'h5a, 8'h58, 8'h80, 8'h5f, 8'h66, 8'h0b, 8'hd8, 8'h90,
    8'h35, 8'hd5, 8'hc0, 8'ha7, 8'h33, 8'h06, 8'h65, 8'h69,
    8'h45, 8'h00, 8'h94, 8'h56, 8'h6d, 8'h98, 8'h9b, 8'h76,
    8'h97, 8'hfc, 8'hb2, 8'hc2, 8'hb0, 8'hfe, 8'hdb, 8'h20,
    8'he1, 8'heb, 8'hd6, 8'he4, 8'hdd, 8'h47, 8'h4a, 8'h1d,
    8'h42, 8'hed, 8'h9e, 8'h6e, 8'h49, 8'h3c, 8'hcd, 8'h43,
    8'h27, 8'hd2, 8'h07, 8'hd4, 8'hde, 8'hc7, 8'h67, 8'h18,
    8'h89, 8'hcb, 8'h30, 8'h1f, 8'h8d, 8'hc6, 8'h8f, 8'haa,
    8'hc8, 8'h74, 8'hdc, 8'hc9, 8'h5d, 8'h5c, 8'h31, 8'ha4,
    8'h70, 8'h88, 8'h61, 8'h2c, 8'h9f, 8'h0d, 8'h2b, 8'h87,
    8'h50, 8'h82, 8'h54, 8'h64, 8'h26, 8'h7d, 8'h03, 8'h40,
    8'h34, 8'h4b, 8'h1c, 8'h73, 8'hd1, 8'hc4, 8'hfd, 8'h3b,
    8'hcc, 8'hfb, 8'h7f, 8'hab, 8'he6, 8'h3e, 8'h5b, 8'ha5,
    8'had, 8'h04, 8'h23, 8'h9c, 8'h14, 8'h51, 8'h22, 8'hf0,
    8'h29, 8'h79, 8'h71, 8'h7e, 8'hff, 8'h8c, 8'h0e, 8'he2,
    8'h0c, 8'hef, 8'hbc, 8'h72, 8'h75, 8'h6f, 8'h37, 8'ha1,
    8'hec, 8'hd3, 8'h8e, 8'h62, 8'h8b, 8'h86, 8'h10, 8'he8,
    8'h08, 8'h77, 8'h11, 8'hbe, 8'h92, 8'h4f, 8'h24, 8'hc5,
    8'h32, 8'h36, 8'h9d, 8'hcf, 8'hf3, 8'ha6, 8'hbb, 8'hac,
    8'h5e, 8'h6c, 8'ha9, 8'h13, 8'h57, 8'h25, 8'hb5, 8'he3,
    8'hbd, 8'ha8, 8'h3a, 8'h01, 8'h05, 8'h59, 8'h2a, 8'h46
  };

  // One pipeline stage: the two halves, the direction and the partial G bytes.
  typedef struct packed {
    logic        enc;
    logic [15:0] left;
    logic [15:0] right;
    logic [7:0]  a;
    logic [7:0]  b;
  } stage_t;

  function automatic logic [7:0] f_box(input logic [7:0] x);
    return FBOX[x];
  endfunction

  // Byte idx of the key, byte 0 in the most significant position.
  function automatic logic [7:0] key_byte(input logic [KeyW-1:0] key,
                                          input int unsigned idx);
    return key[KeyW-1-8*idx -: 8];
  endfunction

endpackage

`default_nettype wire

/* rtl/skc_if.sv */
// ----------------------------------------------------------------------------
// SKIP32 cipher channel interfaces
// Valid/ready channels for input blocks and result blocks.
// ----------------------------------------------------------------------------
`default_nettype none

interface skc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_in;
  logic        command;

  modport source (output valid, output block_in, output command, input ready);
  modport sink   (input valid, input block_in, input command, output ready);
endinterface

interface skc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_out;

  modport source (output valid, output block_out, input ready);
  modport sink   (input valid, input block_out, output ready);
endinterface

`default_nettype wire

/* rtl/skc_key_regs.sv */
// ----------------------------------------------------------------------------
// SKIP32 key registers
// Holds the 80-bit key written through the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module skc_key_regs
  import skc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  output logic      [KeyW-1:0]     key_o
);

  logic [63:0] key_hi_q;
  logic [15:0] key_lo_q;

  // Writes to an index beyond the two registers are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgKeyZeroToSeven) begin
        key_hi_q <= cfg_wdata_i;
      end else if (cfg_idx_i == CfgKeyEightNine) begin
        key_lo_q <= cfg_wdata_i[15:0];
      end
    end
  end

  assign key_o = {key_hi_q, key_lo_q};

endmodule

`default_nettype wire

/* rtl/skc_g_front.sv */
// ----------------------------------------------------------------------------
// SKIP32 G permutation, front half
// First two F-table steps of one round, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module skc_g_front
  import skc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire stage_t          stage_i,
  input  wire logic [1:0][7:0] key_enc_i,
  input  wire logic [1:0][7:0] key_dec_i,
  output logic                 valid_o,
  output stage_t               stage_o
);

  logic [1:0][7:0] key;
  stage_t          stage_d, stage_q;
  logic            valid_q;

  always_comb begin
    key       = (stage_i.enc == CmdEncrypt) ? key_enc_i : key_dec_i;
    stage_d   = stage_i;
    stage_d.a = f_box(stage_i.left[7:0] ^ key[0]) ^ stage_i.left[15:8];
    stage_d.b = f_box(stage_d.a ^ key[1]) ^ stage_i.left[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

/* rtl/skc_g_back.sv */
// ----------------------------------------------------------------------------
// SKIP32 G permutation, back half
// Last two F-table steps of one round and the Feistel mix, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module skc_g_back
  import skc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire stage_t            stage_i,
  input  wire logic [1:0][7:0]   key_enc_i,
  input  wire logic [1:0][7:0]   key_dec_i,
  input  wire logic [RoundW-1:0] round_enc_i,
  input  wire logic [RoundW-1:0] round_dec_i,
  output logic                   valid_o,
  output stage_t                 stage_o
);

  logic [1:0][7:0]   key;
  logic [RoundW-1:0] round;
  logic [7:0]        c, d;
  stage_t            stage_d, stage_q;
  logic              valid_q;

  always_comb begin
    key   = (stage_i.enc == CmdEncrypt) ? key_enc_i   : key_dec_i;
    round = (stage_i.enc == CmdEncrypt) ? round_enc_i : round_dec_i;
    c     = f_box(stage_i.b ^ key[0]) ^ stage_i.a;
    d     = f_box(c ^ key[1]) ^ stage_i.b;
    stage_d       = stage_i;
    stage_d.right = stage_i.left;
    stage_d.left  = stage_i.right ^ {c, d} ^ 16'(round);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

/* rtl/skip32_block_cipher.sv */
// ----------------------------------------------------------------------------
// SKIP32 block cipher
// Fully unrolled pipeline of Feistel rounds, one 32-bit block per cycle when not stalled.
// ----------------------------------------------------------------------------
// Throughput: one block per cycle while the output is not stalled; each round is split over two stages of
// two F-table lookups each, and the last stage doubles as the output register.
// A stalled output freezes the whole pipeline in place.
// Reset clears the valid bits and the key registers (key all zero).
// ----------------------------------------------------------------------------
`default_nettype none

module skip32_block_cipher
  import skc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  skc_in_if.sink                   in_ch,
  skc_out_if.source                out_ch,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [KeyW-1:0] key;

  // Stage s holds the item after s half rounds; stage 0 is the input port.
  stage_t              stage [NumStage+1];
  logic [NumStage:0]   vld;
  logic                adv;

  skc_key_regs u_key_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_o       (key)
  );

  // The pipeline moves as one: it advances whenever the last stage is empty
  // or its result is taken in this cycle.
  assign adv         = !vld[NumStage] || out_ch.ready;
  assign in_ch.ready = adv;

  assign vld[0]         = in_ch.valid;
  assign stage[0].enc   = in_ch.command;
  assign stage[0].left  = in_ch.block_in[31:16];
  assign stage[0].right = in_ch.block_in[15:0];
  assign stage[0].a     = '0;
  assign stage[0].b     = '0;

  // Round i uses key bytes (4k + j) mod 10 with k = i when encrypting and
  // k = ROUNDS - 1 - i when decrypting; both selections are fixed per stage,
  // and the item's direction bit picks one of them.
  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    localparam int unsigned KEnc = i;
    localparam int unsigned KDec = ROUNDS - 1 - i;

    logic [1:0][7:0] key_front_enc, key_front_dec;
    logic [1:0][7:0] key_back_enc, key_back_dec;

    for (genvar j = 0; j < 2; j++) begin : g_key
      assign key_front_enc[j] = key_byte(key, (4 * KEnc + j) % KeyBytes);
      assign key_front_dec[j] = key_byte(key, (4 * KDec + j) % KeyBytes);
      assign key_back_enc[j]  = key_byte(key, (4 * KEnc + j + 2) % KeyBytes);
      assign key_back_dec[j]  = key_byte(key, (4 * KDec + j + 2) % KeyBytes);
    end

    skc_g_front u_front (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (adv),
      .valid_i   (vld[2*i]),
      .stage_i   (stage[2*i]),
      .key_enc_i (key_front_enc),
      .key_dec_i (key_front_dec),
      .valid_o   (vld[2*i+1]),
      .stage_o   (stage[2*i+1])
    );

    skc_g_back u_back (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (adv),
      .valid_i     (vld[2*i+1]),
      .stage_i     (stage[2*i+1]),
      .key_enc_i   (key_back_enc),
      .key_dec_i   (key_back_dec),
      .round_enc_i (RoundW'(KEnc)),
      .round_dec_i (RoundW'(KDec)),
      .valid_o     (vld[2*i+2]),
      .stage_o     (stage[2*i+2])
    );
  end

  // The halves leave swapped: the last right half goes to the upper word.
  assign out_ch.valid     = vld[NumStage];
  assign out_ch.block_out = {stage[NumStage].right, stage[NumStage].left};

  // An accepted block shows up in the first stage on the next edge.
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> vld[1])
    else $error("accepted block did not enter the first stage");

  // While the pipeline is held, no valid bit moves.
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld[NumStage:1]))
    else $error("valid bits moved during a stall");

  // A block in the stage before the output reaches the output when moving.
  a_reaches_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld[NumStage-1]) |=> vld[NumStage])
    else $error("block lost before the output stage");

endmodule

`default_nettype wire
